[rtl/core/crd_pkg.sv]
// crd_pkg: shared types and constants for the character raster draw engine
// no dependencies
package crd_pkg;

	// command codes
	typedef enum logic [2:0] {
		OP_POINT  = 3'd0,
		OP_LINE   = 3'd1,
		OP_RECT   = 3'd2,
		OP_FILL   = 3'd3,
		OP_RING   = 3'd4,
		OP_DISC   = 3'd5,
		OP_CLEAR  = 3'd6,
		OP_READ   = 3'd7
	} op_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_LINE,
		ST_RDWAIT,
		ST_DONE
	} state_t;

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam int FILL_SLACK = 15;

endpackage

[rtl/core/crd_ram.sv]
// crd_ram: generic single-port ram with registered read
// no dependencies
module crd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[rtl/core/character_raster_draw_engine.sv]
// character_raster_draw_engine: top level, command sequencer around the frame ram
// depends on crd_pkg and crd_ram
//
// usage: raise start with a command on operation, coord_a..coord_d, radius and
// paint_char; the transaction is taken when start is high and busy is low.
// busy stays high until the result is shown: done pulses for one cycle with
// pixel_value and accepted. the receiver cannot stall; results are never held.
// a point is written as it is taken, a read waits on the registered ram output,
// a line steps row by row, rect outline and fill, circles and clear scan the
// whole frame, one pixel a cycle, writing the pixels that hit. throughput is
// one command at a time; the single ram port sets the rate.
// after reset the ram is swept to space, one entry a cycle, with busy high.
module character_raster_draw_engine
	import crd_pkg::*;
#(
	parameter int FRAME_WIDTH  = 64,
	parameter int FRAME_HEIGHT = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] operation,
	input  logic [5:0] coord_a,
	input  logic [5:0] coord_b,
	input  logic [5:0] coord_c,
	input  logic [5:0] coord_d,
	input  logic [5:0] radius,
	input  logic [7:0] paint_char,
	output logic       done,
	output logic [7:0] pixel_value,
	output logic       accepted
);
	localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(FRAME_WIDTH);
	localparam int RW = $clog2(FRAME_HEIGHT);
	localparam int XW = (CW > RW) ? CW : RW;

	state_t state_q, state_d;
	op_t    op_q;
	logic [5:0] a_q, b_q, c_q, d_q;
	logic [7:0] ch_q;
	logic [12:0] rr_q;                   // r*r
	logic [12:0] rlo_q, rhi_q;           // r(r-1), r(r+1)
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic ok_q;
	logic [7:0] pix_q;

	// line state
	logic signed [8:0] lx_q, ly_q, ldx_q, ldy_q;
	logic lneg_q;
	logic signed [12:0] acc_q;

	// ram port
	logic          we;
	logic [AW-1:0] addr;
	logic [7:0]    wdata, rdata;

	crd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	// bounds checks on the incoming command
	logic a_inw, b_inh, c_inw, d_inh, a_inh, b_inw;
	assign a_inw = 32'(coord_a) < FRAME_WIDTH;
	assign b_inh = 32'(coord_b) < FRAME_HEIGHT;
	assign c_inw = 32'(coord_c) < FRAME_WIDTH;
	assign d_inh = 32'(coord_d) < FRAME_HEIGHT;
	assign a_inh = 32'(coord_a) < FRAME_HEIGHT;
	assign b_inw = 32'(coord_b) < FRAME_WIDTH;

	logic cmd_ok;
	always_comb begin
		unique case (op_t'(operation))
			OP_POINT, OP_READ: cmd_ok = a_inw & b_inh;
			OP_RECT, OP_FILL:  cmd_ok = a_inw & b_inh & c_inw & d_inh;
			OP_RING, OP_DISC:  cmd_ok = a_inh & b_inw;
			default:           cmd_ok = 1'b1;
		endcase
	end

	// scan pixel test
	logic signed [9:0] di, dj;
	logic [17:0] sq_dist;
	logic in_x, in_y, hit;
	logic [8:0] col9, row9;
	assign col9 = 9'(col_q);
	assign row9 = 9'(row_q);
	assign di = $signed({1'b0, row9}) - $signed({4'b0, a_q});
	assign dj = $signed({1'b0, col9}) - $signed({4'b0, b_q});
	assign sq_dist = 18'(di * di) + 18'(dj * dj);
	assign in_x = (col9 >= {3'b0, a_q}) && (col9 <= {3'b0, c_q});
	assign in_y = (row9 >= {3'b0, b_q}) && (row9 <= {3'b0, d_q});
	always_comb begin
		case (op_q)
			OP_FILL: hit = in_x && in_y;
			OP_RECT: hit = (in_x && (row9 == {3'b0, b_q} || row9 == {3'b0, d_q}))
				|| (in_y && (col9 == {3'b0, a_q} || col9 == {3'b0, c_q}));
			OP_RING: hit = (sq_dist >= 18'(rlo_q)) && (sq_dist <= 18'(rhi_q));
			OP_DISC: hit = ($signed({1'b0, sq_dist}) <
				$signed({6'b0, rr_q}) - 19'sd15);
			default: hit = 1'b1;
		endcase
	end

	logic last_px;
	assign last_px = (32'(col_q) == FRAME_WIDTH - 1) && (32'(row_q) == FRAME_HEIGHT - 1);

	logic line_on;
	assign line_on = (lx_q >= 0) && (32'(lx_q) < FRAME_WIDTH) && (32'(ly_q) < FRAME_HEIGHT);

	// next state and ram control
	always_comb begin
		state_d = state_q;
		we = 1'b0;
		wdata = ch_q;
		addr = AW'(row_q) * AW'(FRAME_WIDTH) + AW'(col_q);
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_INIT: begin
				we = 1'b1;
				wdata = BLANK_CHAR;
				if (last_px) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				addr = AW'(RW'(coord_b)) * AW'(FRAME_WIDTH) + AW'(CW'(coord_a));
				if (start) begin
					if (!cmd_ok) state_d = ST_DONE;
					else begin
						unique case (op_t'(operation))
							OP_POINT: begin
								we = 1'b1;
								wdata = paint_char;
								state_d = ST_DONE;
							end
							OP_READ: state_d = ST_RDWAIT;
							OP_LINE: state_d = ST_LINE;
							default: state_d = ST_SCAN;
						endcase
					end
				end
			end
			ST_SCAN: begin
				we = hit;
				wdata = (op_q == OP_CLEAR) ? BLANK_CHAR : ch_q;
				if (last_px) state_d = ST_DONE;
			end
			ST_LINE: begin
				addr = AW'(ly_q[XW-1:0]) * AW'(FRAME_WIDTH) + AW'(lx_q[XW-1:0]);
				we = (ly_q <= ldy_q + $signed({3'b0, b_q})) && line_on;
				if (ly_q > $signed({3'b0, d_q})) begin
					we = 1'b0;
					state_d = ST_DONE;
				end
			end
			ST_RDWAIT: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			col_q <= '0;
			row_q <= '0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= (state_q == ST_DONE);
			if (state_q == ST_INIT || state_q == ST_SCAN) begin
				if (32'(col_q) == FRAME_WIDTH - 1) begin
					col_q <= '0;
					row_q <= (32'(row_q) == FRAME_HEIGHT - 1) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// command and datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q <= op_t'(operation);
			a_q <= coord_a; b_q <= coord_b; c_q <= coord_c; d_q <= coord_d;
			ch_q <= paint_char;
			rr_q <= 13'(radius * radius);
			rlo_q <= 13'(radius * radius) - 13'(radius);
			rhi_q <= 13'(radius * radius) + 13'(radius);
			ok_q <= cmd_ok;
			pix_q <= '0;
			lx_q <= $signed({3'b0, coord_a});
			ly_q <= $signed({3'b0, coord_b});
			lneg_q <= coord_c < coord_a;
			ldx_q <= (coord_c < coord_a) ? 9'(coord_a - coord_c) : 9'(coord_c - coord_a);
			ldy_q <= $signed({3'b0, coord_d}) - $signed({3'b0, coord_b});
			acc_q <= 13'sd2 * ((coord_c < coord_a) ? $signed(13'(coord_a - coord_c))
				: $signed(13'(coord_c - coord_a)))
				- ($signed({7'b0, coord_d}) - $signed({7'b0, coord_b}));
		end
		if (state_q == ST_LINE) begin
			ly_q <= ly_q + 9'sd1;
			if (acc_q > 0) begin
				lx_q <= lneg_q ? lx_q - 9'sd1 : lx_q + 9'sd1;
				acc_q <= acc_q + 13'sd2 * (13'(ldx_q) - 13'(ldy_q));
			end else begin
				acc_q <= acc_q + 13'sd2 * 13'(ldx_q);
			end
		end
		if (state_q == ST_RDWAIT) pix_q <= rdata;
		if (state_q == ST_DONE) begin
			pixel_value <= pix_q;
			accepted <= ok_q;
		end
	end
endmodule

[rtl/core/crd_checker.sv]
// crd_checker: port-level assertions for the draw engine, bound to the top level
// depends on crd_pkg and character_raster_draw_engine
module crd_port_checker
	import crd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [7:0] pixel_value,
	input logic [2:0] operation,
	input logic accepted
);
	logic rd_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_q <= 1'b0;
		else if (start && !busy) rd_q <= (op_t'(operation) == OP_READ);
	end

	// a taken transaction makes the engine busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("not busy after transaction");
	// done only ends a busy period
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	// done is a single pulse
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	// non-read commands return zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rd_q |-> pixel_value == 8'd0) else $error("nonzero pixel");
	// rejected commands return zero
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		done && !accepted |-> pixel_value == 8'd0) else $error("rejected with data");
endmodule

bind character_raster_draw_engine crd_port_checker u_crd_checker (.*);

[sim/crd_checker.sv]
`timescale 1ns / 1ps
// crd_checker: watches the command and result channels of the draw engine,
// keeps its own copy of the frame and compares every result; uses crd_pkg
module crd_checker
	import crd_pkg::*;
#(
	parameter int FRAME_WIDTH  = 64,
	parameter int FRAME_HEIGHT = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  op_t        operation,
	input  logic [5:0] coord_a,
	input  logic [5:0] coord_b,
	input  logic [5:0] coord_c,
	input  logic [5:0] coord_d,
	input  logic [5:0] radius,
	input  logic [7:0] paint_char,
	input  logic       done,
	input  logic [7:0] pixel_value,
	input  logic       accepted,
	output int         fail_count,
	output int         pending
);

	typedef struct packed {
		logic [7:0] pixel;
		logic       ok;
	} outcome_t;

	logic [7:0] shadow_frame [FRAME_WIDTH*FRAME_HEIGHT];
	outcome_t   outcomes_due [$];

	function automatic void plot(int row, int col, logic [7:0] ch);
		if (row < 0 || col < 0 || row >= FRAME_HEIGHT || col >= FRAME_WIDTH)
			return;
		shadow_frame[row*FRAME_WIDTH + col] = ch;
	endfunction

	function automatic void blank_frame();
		foreach (shadow_frame[k])
			shadow_frame[k] = BLANK_CHAR;
	endfunction

	// works out the result of one command and applies it to the shadow frame
	function automatic outcome_t draw_command(op_t op, int a, int b, int c, int d, int r,
			logic [7:0] ch);
		outcome_t res;
		int dx, dy, step, acc, x, sq_dist;
		res = '0;
		case (op)
			OP_POINT: begin
				if (a < FRAME_WIDTH && b < FRAME_HEIGHT) begin
					plot(b, a, ch);
					res.ok = 1'b1;
				end
			end
			OP_LINE: begin
				// one row per step, column moves at most once a row
				dx = c - a;
				dy = d - b;
				step = 1;
				if (dx < 0) begin
					dx = -dx;
					step = -1;
				end
				acc = 2*dx - dy;
				x = a;
				for (int y = b; y <= d; y++) begin
					plot(y, x, ch);
					if (acc > 0) begin
						x += step;
						acc += 2*(dx - dy);
					end else begin
						acc += 2*dx;
					end
				end
				res.ok = 1'b1;
			end
			OP_RECT, OP_FILL: begin
				if (a < FRAME_WIDTH && b < FRAME_HEIGHT && c < FRAME_WIDTH && d < FRAME_HEIGHT) begin
					res.ok = 1'b1;
					if (op == OP_FILL) begin
						for (int i = b; i <= d; i++)
							for (int j = a; j <= c; j++)
								plot(i, j, ch);
					end else begin
						for (int j = a; j <= c; j++) begin
							plot(b, j, ch);
							plot(d, j, ch);
						end
						for (int i = b; i <= d; i++) begin
							plot(i, a, ch);
							plot(i, c, ch);
						end
					end
				end
			end
			OP_RING, OP_DISC: begin
				if (a < FRAME_HEIGHT && b < FRAME_WIDTH) begin
					res.ok = 1'b1;
					for (int i = 0; i < FRAME_HEIGHT; i++)
						for (int j = 0; j < FRAME_WIDTH; j++) begin
							sq_dist = (i - a)*(i - a) + (j - b)*(j - b);
							if (op == OP_DISC ? sq_dist < r*r - FILL_SLACK
									: (sq_dist >= r*(r - 1) && sq_dist <= r*(r + 1)))
								plot(i, j, ch);
						end
				end
			end
			OP_CLEAR: begin
				blank_frame();
				res.ok = 1'b1;
			end
			default: begin
				if (a < FRAME_WIDTH && b < FRAME_HEIGHT) begin
					res.pixel = shadow_frame[b*FRAME_WIDTH + a];
					res.ok = 1'b1;
				end
			end
		endcase
		return res;
	endfunction

	// predict on each command transaction, compare on each result strobe
	always @(posedge clk or negedge arst_n) begin
		outcome_t due;
		if (!arst_n) begin
			blank_frame();
			outcomes_due.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (outcomes_due.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: pixel %0h accepted %0b", pixel_value, accepted);
					fail_count <= fail_count + 1;
				end else begin
					due = outcomes_due.pop_front();
					if (due.pixel !== pixel_value || due.ok !== accepted) begin
						if (fail_count < 10)
							$display("mismatch: expected pixel %0h accepted %0b, got pixel %0h accepted %0b",
								due.pixel, due.ok, pixel_value, accepted);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				outcomes_due.push_back(draw_command(operation, coord_a, coord_b, coord_c, coord_d,
					radius, paint_char));
			pending <= outcomes_due.size();
		end
	end

endmodule

[sim/character_raster_draw_engine_tb.sv]
`timescale 1ns / 1ps
// character_raster_draw_engine_tb: stimulus and verdict for the draw engine
// depends on crd_pkg, crd_checker and the engine itself
module character_raster_draw_engine_tb;
	import crd_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	op_t        operation = OP_POINT;
	logic [5:0] coord_a = '0;
	logic [5:0] coord_b = '0;
	logic [5:0] coord_c = '0;
	logic [5:0] coord_d = '0;
	logic [5:0] radius = '0;
	logic [7:0] paint_char = '0;
	logic       done;
	logic [7:0] pixel_value;
	logic       accepted;
	int         fail_count;
	int         pending;
	int         cycles = 0;
	int         gap_pct = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	character_raster_draw_engine i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .operation(operation),
		.coord_a(coord_a), .coord_b(coord_b), .coord_c(coord_c), .coord_d(coord_d),
		.radius(radius), .paint_char(paint_char), .done(done), .pixel_value(pixel_value),
		.accepted(accepted)
	);

	crd_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .operation(operation),
		.coord_a(coord_a), .coord_b(coord_b), .coord_c(coord_c), .coord_d(coord_d),
		.radius(radius), .paint_char(paint_char), .done(done), .pixel_value(pixel_value),
		.accepted(accepted), .fail_count(fail_count), .pending(pending)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// offers one command and holds it until the transaction completes
	task automatic issue(op_t op, int a, int b, int c, int d, int r, int ch);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		coord_a <= 6'(a);
		coord_b <= 6'(b);
		coord_c <= 6'(c);
		coord_d <= 6'(d);
		radius <= 6'(r);
		paint_char <= 8'(ch);
		// busy is steady at the falling edge; the next rising edge takes it
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	// mostly on-screen coordinates, now and then anywhere in the field
	function automatic int pick(int span);
		return ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(span - 1);
	endfunction

	task automatic random_command();
		int sel;
		op_t op;
		sel = $urandom_range(99);
		if (sel < 35)
			op = OP_READ;
		else if (sel < 55)
			op = OP_POINT;
		else if (sel < 72)
			op = OP_LINE;
		else if (sel < 80)
			op = OP_RECT;
		else if (sel < 87)
			op = OP_FILL;
		else if (sel < 92)
			op = OP_RING;
		else if (sel < 97)
			op = OP_DISC;
		else
			op = OP_CLEAR;
		if (op == OP_RING || op == OP_DISC)
			issue(op, pick(32), pick(64), $urandom_range(63), $urandom_range(63),
				($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(20),
				$urandom_range(255));
		else
			issue(op, pick(64), pick(32), pick(64), pick(32), $urandom_range(63),
				$urandom_range(255));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corners, rejections, reads, line shapes, rectangles, circles and a clear
		issue(OP_POINT, 0, 0, 0, 0, 0, 8'h00);
		issue(OP_POINT, 63, 31, 63, 63, 63, 8'hff);
		issue(OP_POINT, 5, 32, 0, 0, 0, 8'h41);
		issue(OP_READ, 0, 0, 0, 0, 0, 0);
		issue(OP_READ, 63, 31, 0, 0, 0, 0);
		issue(OP_READ, 10, 63, 0, 0, 0, 0);
		issue(OP_LINE, 2, 1, 20, 25, 0, 8'h2a);
		issue(OP_LINE, 40, 0, 3, 12, 0, 8'h2b);
		issue(OP_LINE, 10, 20, 30, 5, 0, 8'h2c);
		issue(OP_LINE, 60, 28, 63, 63, 0, 8'h2d);
		issue(OP_READ, 2, 1, 0, 0, 0, 0);
		issue(OP_RECT, 0, 0, 63, 31, 0, 8'h23);
		issue(OP_FILL, 4, 4, 12, 9, 0, 8'h2e);
		issue(OP_RECT, 30, 20, 10, 5, 0, 8'h2f);
		issue(OP_FILL, 0, 0, 10, 40, 0, 8'h30);
		issue(OP_READ, 6, 6, 0, 0, 0, 0);
		issue(OP_RING, 0, 0, 0, 0, 0, 8'h6f);
		issue(OP_RING, 16, 32, 0, 0, 63, 8'h6f);
		issue(OP_DISC, 16, 32, 0, 0, 3, 8'h40);
		issue(OP_DISC, 15, 31, 0, 0, 10, 8'h40);
		issue(OP_RING, 40, 10, 0, 0, 5, 8'h6f);
		issue(OP_READ, 31, 15, 0, 0, 0, 0);
		issue(OP_CLEAR, 0, 0, 0, 0, 0, 0);
		issue(OP_READ, 31, 15, 0, 0, 0, 0);

		// random, three phases with different idling, the last with none
		gap_pct = 22;
		repeat (90) random_command();
		gap_pct = 60;
		repeat (90) random_command();
		gap_pct = 0;
		repeat (90) random_command();
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
